### design/evf_pkg.sv
// Shared constants, register codes and unit handshake types for the velocity filter.
package evf_pkg;

	localparam logic [31:0] RPC_RST   = 32'd13176795;
	localparam logic [26:0] TAU_RST   = 27'd10000;
	localparam logic [31:0] STALL_RST = 32'd10000;
	localparam logic [31:0] US_PER_S  = 32'd1000000;

	localparam logic [1:0] CFG_RPC   = 2'd0;
	localparam logic [1:0] CFG_TAU   = 2'd1;
	localparam logic [1:0] CFG_STALL = 2'd2;

	localparam int MCAND_W   = 64;
	localparam int MPLIER_W  = 32;
	localparam int PROD_W    = MCAND_W + MPLIER_W;
	localparam int MUL_CNT_W = $clog2(MPLIER_W);

	localparam int DVD_W     = 68;
	localparam int DVS_W     = 33;
	localparam int QUO_W     = 33;
	localparam int DIV_CNT_W = 7;

	localparam logic [DIV_CNT_W-1:0] VEL_DIV_STEPS = 7'd68;
	localparam logic [DIV_CNT_W-1:0] FLT_DIV_STEPS = 7'd64;

	typedef struct packed {
		logic                start;
		logic [MCAND_W-1:0]  mcand;
		logic [MPLIER_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic                 start;
		logic [DVD_W-1:0]     dividend;
		logic [DVS_W-1:0]     divisor;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

### design/evf_in_if.sv
// Sample channel: function code, encoder count and timestamp.
interface evf_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] count;
	logic        [31:0] time_us;

	modport source (output valid, func, count, time_us, input ready);
	modport sink   (input valid, func, count, time_us, output ready);
endinterface

### design/evf_out_if.sv
// Result channel: filtered velocity and angle.
interface evf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_velocity;
	logic signed [31:0] angle;

	modport source (output valid, filtered_velocity, angle, input ready);
	modport sink   (input valid, filtered_velocity, angle, output ready);
endinterface

### design/evf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module evf_mul import evf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output unit_sts_t         sts,
	output logic [PROD_W-1:0] prod
);

	logic [MCAND_W-1:0]   mcand_q;
	logic [MCAND_W-1:0]   hi_q;
	logic [MPLIER_W-1:0]  lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MCAND_W:0]     sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign prod = {hi_q, lo_q};
	assign sts  = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MPLIER_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			hi_q    <= '0;
			lo_q    <= req.mplier;
		end else if (busy_q) begin
			hi_q <= sum[MCAND_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

endmodule

### design/evf_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, with overflow flag.
module evf_div import evf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output unit_sts_t        sts,
	output logic [QUO_W-1:0] quo,
	output logic             ovf
);

	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       r2;
	logic [DVS_W:0]       diff;
	logic                 ge;

	assign r2   = {rem_q, dvd_q[DVD_W-1]};
	assign diff = r2 - {1'b0, dvs_q};
	assign ge   = (r2 >= {1'b0, dvs_q});
	assign quo  = quo_q;
	assign ovf  = ovf_q;
	assign sts  = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : r2[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

endmodule

### design/encoder_velocity_filter.sv
// Encoder velocity estimator with first-order low-pass filter, top level.
//
//  port     dir   payload                              accepted when
//  sample   sink  func, count[31:0], time_us[31:0]     valid && ready
//  result   src   filtered_velocity[31:0], angle[31:0] valid && ready
//  cfg_*    sink  cfg_idx[1:0], cfg_data[31:0]         cfg_we
//
// Work per item depends on its kind: a sample whose count changed, one that did
// not, or a reset item; a zero filter denominator skips the filter multiply and
// divide. The serial multiplier and the serial divider do the arithmetic.
// One item is worked at a time; ready is high only while the sequencer idles.
// A finished result sits in the output register, so the next item is taken
// while it waits; the sequencer stalls only when a second result is done before
// the first has left. arst_n clears all tracking state and the result valid flag.
module encoder_velocity_filter import evf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_data,
	evf_in_if.sink       sample,
	evf_out_if.source    result
);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_VMUL1 = 4'd2;
	localparam logic [3:0] S_VMUL2 = 4'd3;
	localparam logic [3:0] S_VDIV  = 4'd4;
	localparam logic [3:0] S_FPREP = 4'd5;
	localparam logic [3:0] S_FMUL  = 4'd6;
	localparam logic [3:0] S_FDIV  = 4'd7;
	localparam logic [3:0] S_APREP = 4'd8;
	localparam logic [3:0] S_AMUL  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]  state_q;

	// configuration
	logic [31:0] rpc_q;
	logic [26:0] tau_q;
	logic [31:0] stall_q;

	// tracking state
	logic [31:0] last_count_q;
	logic [31:0] last_change_q;
	logic [31:0] last_check_q;
	logic [31:0] raw_q;
	logic [31:0] smooth_q;

	// item under work
	logic        func_q;
	logic [31:0] count_q;
	logic [31:0] now_q;
	logic [31:0] dtc_q;
	logic [31:0] dtk_q;
	logic        vneg_q;
	logic        fneg_q;
	logic [32:0] den_q;
	logic [31:0] angle_q;

	// output register
	logic        res_valid_q;
	logic [31:0] res_vel_q;
	logic [31:0] res_ang_q;
	logic        res_load;

	mul_req_t          mul_req;
	unit_sts_t         mul_sts;
	logic [PROD_W-1:0] prod;
	div_req_t          div_req;
	unit_sts_t         div_sts;
	logic [QUO_W-1:0]  quo;
	logic              ovf;

	// combinational helpers
	logic [31:0] dtc, dtk;
	logic [32:0] delta, vmag;
	logic        chg;
	logic [32:0] fdiff, fmag, den;
	logic [31:0] amag;
	logic [32:0] vcap, vsat;
	logic [31:0] vel_new;
	logic [33:0] fstep, sm_sum;
	logic [47:0] araw, acap, asat;
	logic [31:0] ang_new;

	assign dtc   = now_q - last_change_q;
	assign dtk   = now_q - last_check_q;
	assign delta = {count_q[31], count_q} - {last_count_q[31], last_count_q};
	assign vmag  = delta[32] ? (33'd0 - delta) : delta;
	assign chg   = (count_q != last_count_q) && (dtc != 32'd0);

	assign fdiff = {raw_q[31], raw_q} - {smooth_q[31], smooth_q};
	assign fmag  = fdiff[32] ? (33'd0 - fdiff) : fdiff;
	assign den   = {6'd0, tau_q} + {1'b0, dtk_q};

	assign amag  = count_q[31] ? (32'd0 - count_q) : count_q;

	// raw velocity: quotient clamped to the signed range
	assign vcap    = vneg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
	assign vsat    = (ovf || (quo > vcap)) ? vcap : quo;
	assign vel_new = vneg_q ? (32'd0 - vsat[31:0]) : vsat[31:0];

	// filter step never leaves the range between old value and raw
	assign fstep  = fneg_q ? (34'd0 - {1'b0, quo}) : {1'b0, quo};
	assign sm_sum = {{2{smooth_q[31]}}, smooth_q} + fstep;

	// angle: Q0.32 times count, down to Q16.16, clamped
	assign araw    = prod[63:16];
	assign acap    = count_q[31] ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
	assign asat    = (araw > acap) ? acap : araw;
	assign ang_new = count_q[31] ? (32'd0 - asat[31:0]) : asat[31:0];

	// finished item moves into the output register once it is free
	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	assign sample.ready             = (state_q == S_IDLE);
	assign result.valid             = res_valid_q;
	assign result.filtered_velocity = res_vel_q;
	assign result.angle             = res_ang_q;

	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			S_PREP: begin
				if (!func_q && chg) begin
					mul_req = '{start: 1'b1, mcand: {31'd0, vmag}, mplier: US_PER_S};
				end
			end
			S_VMUL1: begin
				if (mul_sts.done) begin
					mul_req = '{start: 1'b1, mcand: prod[63:0], mplier: rpc_q};
				end
			end
			S_VMUL2: begin
				if (mul_sts.done) begin
					div_req = '{start: 1'b1, dividend: prod[83:16],
						divisor: {1'b0, dtc_q}, steps: VEL_DIV_STEPS};
				end
			end
			S_FPREP: begin
				if (den != 33'd0) begin
					mul_req = '{start: 1'b1, mcand: {31'd0, fmag}, mplier: dtk_q};
				end
			end
			S_FMUL: begin
				if (mul_sts.done) begin
					div_req = '{start: 1'b1, dividend: {prod[63:0], 4'd0},
						divisor: den_q, steps: FLT_DIV_STEPS};
				end
			end
			S_APREP: begin
				mul_req = '{start: 1'b1, mcand: {32'd0, amag}, mplier: rpc_q};
			end
			default: begin
			end
		endcase
	end

	evf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.sts    (mul_sts),
		.prod   (prod)
	);

	evf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quo    (quo),
		.ovf    (ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rpc_q         <= RPC_RST;
			tau_q         <= TAU_RST;
			stall_q       <= STALL_RST;
			last_count_q  <= '0;
			last_change_q <= '0;
			last_check_q  <= '0;
			raw_q         <= '0;
			smooth_q      <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_RPC:   rpc_q   <= cfg_data;
					CFG_TAU:   tau_q   <= cfg_data[26:0];
					CFG_STALL: stall_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (func_q) begin
						// position reset: restart the change timer
						last_count_q  <= '0;
						last_change_q <= now_q;
						state_q       <= S_DONE;
					end else if (chg) begin
						state_q <= S_VMUL1;
					end else begin
						if (dtc > stall_q) begin
							raw_q <= '0;
						end
						state_q <= S_FPREP;
					end
				end
				S_VMUL1: begin
					if (mul_sts.done) begin
						state_q <= S_VMUL2;
					end
				end
				S_VMUL2: begin
					if (mul_sts.done) begin
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (div_sts.done) begin
						raw_q         <= vel_new;
						last_count_q  <= count_q;
						last_change_q <= now_q;
						state_q       <= S_FPREP;
					end
				end
				S_FPREP: begin
					last_check_q <= now_q;
					state_q      <= (den != 33'd0) ? S_FMUL : S_APREP;
				end
				S_FMUL: begin
					if (mul_sts.done) begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_sts.done) begin
						smooth_q <= sm_sum[31:0];
						state_q  <= S_APREP;
					end
				end
				S_APREP: begin
					state_q <= S_AMUL;
				end
				S_AMUL: begin
					if (mul_sts.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and working values
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			func_q  <= sample.func;
			count_q <= sample.count;
			now_q   <= sample.time_us;
		end
		if (state_q == S_PREP) begin
			dtc_q   <= dtc;
			dtk_q   <= dtk;
			vneg_q  <= delta[32];
			angle_q <= '0;
		end
		if (state_q == S_FPREP) begin
			den_q  <= den;
			fneg_q <= fdiff[32];
		end
		if (state_q == S_AMUL && mul_sts.done) begin
			angle_q <= ang_new;
		end
		if (res_load) begin
			res_vel_q <= smooth_q;
			res_ang_q <= angle_q;
		end
	end

`ifndef SYNTHESIS
	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_sts.busy)
		else $error("multiplier started while busy");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (!div_sts.busy && div_req.divisor != '0))
		else $error("divider started while busy or with zero divisor");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy together");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (state_q == S_PREP))
		else $error("accepted item did not start work");
`endif

endmodule
